// File: src/bpr_pkg.sv
// ----------------------------------------------------------------------------
// bpr_pkg
// Shared types and constants of the BMP pixel row decoder: stream widths,
// register indexes, depth mode codes and the job record between stages.
// ----------------------------------------------------------------------------
package bpr_pkg;

	// Stream payload widths (whole bytes) and output row and column field widths
	localparam int S_DATA_W   = 48;
	localparam int M_DATA_W   = 56;
	localparam int ROW_OUT_W  = 12;
	localparam int COL_OUT_W  = 12;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_DOWN   = 2'd3;

	// Depth mode codes
	localparam logic [2:0] MODE_1BPP  = 3'd0;
	localparam logic [2:0] MODE_2BPP  = 3'd1;
	localparam logic [2:0] MODE_4BPP  = 3'd2;
	localparam logic [2:0] MODE_8BPP  = 3'd3;
	localparam logic [2:0] MODE_24BPP = 3'd4;
	localparam logic [2:0] MODE_32BPP = 3'd5;

	// Input item kinds
	localparam logic KIND_PALETTE = 1'b0;
	localparam logic KIND_DATA    = 1'b1;

	// Work handed from the position tracker to the pixel expander.
	// color packs blue in [7:0], green [15:8], red [23:16], alpha [31:24].
	typedef struct packed {
		logic        is_write;   // palette entry write
		logic [7:0]  pal_idx;
		logic [31:0] color;      // write data, or the gathered direct pixel
		logic [7:0]  data_byte;
		logic [1:0]  bpp_log;    // log2 of bits per pixel for indexed modes
		logic        direct;     // 24 or 32 bit pixel
		logic [3:0]  count;      // pixels this byte gives, 0 to 8
		logic        img_done;   // final pixel of this job ends the image
	} job_t;

endpackage

// File: src/bmp_pixel_row_decoder_top.sv
// ----------------------------------------------------------------------------
// bmp_pixel_row_decoder_top
// BMP pixel array decoder: palette load, 1/2/4/8 bit index unpacking with
// palette lookup, 24/32 bit BGR(A) gathering, row padding and row order.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake          Payload
// s_*      in         s_tvalid/s_tready  tdata: palette_index, entry_blue,
//                                        entry_green, entry_red, entry_alpha,
//                                        data_byte; tuser: kind
// m_*      out        m_tvalid/m_tready  tdata: pixel_row, pixel_col, red,
//                                        green, blue, alpha; tlast:
//                                        last_in_run; tuser: image_done
// cfg_*    in         cfg_valid/ready    cfg_index, cfg_data
//
// A byte that yields several pixels is expanded pixel by pixel, paced by
// the single palette read port that serves one lookup per cycle while the
// output is not stalled. Each byte waits in the job register, its pixels in the output register.
// Reset clears position and configuration at once; palette contents are not
// cleared. A stalled m_tready holds the output register; the input stage
// keeps one job waiting and accepts again as soon as that job drains.
//
module bmp_pixel_row_decoder_top import bpr_pkg::*; #(
	parameter int MAX_WIDTH     = 4096,
	parameter int MAX_HEIGHT    = 4096,
	parameter int PALETTE_DEPTH = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_DATA_W-1:0]   s_tdata,   // palette_index, entry_blue, entry_green,
	                                         // entry_red, entry_alpha, data_byte
	input  logic [0:0]            s_tuser,   // kind
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_DATA_W-1:0]   m_tdata,   // pixel_row, pixel_col, red, green,
	                                         // blue, alpha
	output logic                  m_tlast,
	output logic [0:0]            m_tuser,   // image_done
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int COL_W = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	job_t             job;
	logic             job_vld;
	logic             job_take;
	logic [COL_W-1:0] job_col;
	logic [ROW_W-1:0] job_row;

	bpr_track #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.COL_W      (COL_W),
		.ROW_W      (ROW_W)
	) u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.job       (job),
		.job_vld   (job_vld),
		.job_col   (job_col),
		.job_row   (job_row),
		.job_take  (job_take)
	);

	bpr_expand #(
		.PALETTE_DEPTH (PALETTE_DEPTH),
		.COL_W         (COL_W),
		.ROW_W         (ROW_W)
	) u_expand (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (job),
		.job_vld  (job_vld),
		.job_col  (job_col),
		.job_row  (job_row),
		.job_take (job_take),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

// File: src/bpr_track.sv
// ----------------------------------------------------------------------------
// bpr_track
// Configuration registers and row position tracking. Takes one file byte or
// palette entry per transfer, works out which pixels it yields and registers a job.
// ----------------------------------------------------------------------------
module bpr_track import bpr_pkg::*; #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096,
	parameter int COL_W      = $clog2(MAX_WIDTH + 1),
	parameter int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_DATA_W-1:0]   s_tdata,
	input  logic [0:0]            s_tuser,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output job_t                  job,
	output logic                  job_vld,
	output logic [COL_W-1:0]      job_col,
	output logic [ROW_W-1:0]      job_row,
	input  logic                  job_take
);

	localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
	localparam int BYTE_W = $clog2(4 * MAX_WIDTH + 4);
	localparam int DIM_WIDTH = CFG_DATA_W;

	// Configuration registers
	logic [2:0]            mode_q;
	logic [DIM_WIDTH-1:0]  width_q;
	logic [DIM_WIDTH-1:0]  height_q;
	logic                  top_down_q;

	// Position state
	logic [BYTE_W-1:0] byte_in_row_q;
	logic [COL_W-1:0]  col_q;
	logic [HGT_W-1:0]  rows_done_q;
	logic [23:0]       gath_q;
	logic [1:0]        phase_q;

	// Job stage
	job_t              job_s1;
	logic              job_vld_s1;
	logic [COL_W-1:0]  job_col_s1;
	logic [ROW_W-1:0]  job_row_s1;

	// Decode
	logic [31:0]       w32, h32;
	logic [COL_W-1:0]  eff_w;
	logic [HGT_W-1:0]  eff_h;
	logic [1:0]        bpp_log;
	logic              direct, is24, is32;
	logic [BYTE_W-1:0] wb, data_bytes, padded, byte_inc;
	logic              in_data, row_end, last_row, col_ok;
	logic [COL_W-1:0]  rem, new_col;
	logic [3:0]        cnt_full, n_pix;
	logic [1:0]        last_ph, phase_d;
	logic [23:0]       gath_d;
	logic [31:0]       dcolor;
	logic [ROW_W-1:0]  cur_row;
	logic              img_done;
	logic              s_acc;
	logic [7:0]        din;
	job_t              job_d;

	assign cfg_ready = 1'b1;
	assign s_tready  = !job_vld_s1 || job_take;
	assign s_acc     = s_tvalid && s_tready;
	assign din       = s_tdata[47:40];

	// Work out what the current byte yields
	always_comb begin
		w32 = 32'(width_q);
		h32 = 32'(height_q);
		if (w32 == 32'd0)
			eff_w = COL_W'(1);
		else if (w32 > 32'(MAX_WIDTH))
			eff_w = COL_W'(MAX_WIDTH);
		else
			eff_w = COL_W'(width_q);
		if (h32 == 32'd0)
			eff_h = HGT_W'(1);
		else if (h32 > 32'(MAX_HEIGHT))
			eff_h = HGT_W'(MAX_HEIGHT);
		else
			eff_h = HGT_W'(height_q);

		direct  = 1'b0;
		is24    = 1'b0;
		is32    = 1'b0;
		case (mode_q)
			MODE_1BPP:  bpp_log = 2'd0;
			MODE_2BPP:  bpp_log = 2'd1;
			MODE_4BPP:  bpp_log = 2'd2;
			MODE_24BPP: begin
				bpp_log = 2'd3;
				direct  = 1'b1;
				is24    = 1'b1;
			end
			MODE_32BPP: begin
				bpp_log = 2'd3;
				direct  = 1'b1;
				is32    = 1'b1;
			end
			default:    bpp_log = 2'd3;
		endcase

		// Row length in bytes, then padded to four
		wb = BYTE_W'(eff_w);
		if (direct) begin
			data_bytes = is24 ? (wb + (wb << 1)) : (wb << 2);
		end else begin
			case (bpp_log)
				2'd0:    data_bytes = (wb + BYTE_W'(7)) >> 3;
				2'd1:    data_bytes = (wb + BYTE_W'(3)) >> 2;
				2'd2:    data_bytes = (wb + BYTE_W'(1)) >> 1;
				default: data_bytes = wb;
			endcase
		end
		padded   = (data_bytes + BYTE_W'(3)) & ~BYTE_W'(3);
		in_data  = byte_in_row_q < data_bytes;
		byte_inc = byte_in_row_q + BYTE_W'(1);
		row_end  = byte_inc >= padded;

		last_row = rows_done_q == (eff_h - HGT_W'(1));
		cur_row  = top_down_q ? ROW_W'(rows_done_q)
		                      : ROW_W'(eff_h - HGT_W'(1) - rows_done_q);

		col_ok   = col_q < eff_w;
		rem      = eff_w - col_q;
		cnt_full = 4'd8 >> bpp_log;
		last_ph  = is24 ? 2'd2 : 2'd3;

		n_pix   = 4'd0;
		gath_d  = gath_q;
		phase_d = phase_q;
		dcolor  = 32'd0;
		if (in_data) begin
			if (!direct) begin
				// Indexed pixels: cut at the image width
				if (col_ok)
					n_pix = (rem < COL_W'(cnt_full)) ? 4'(rem) : cnt_full;
			end else if (phase_q < last_ph) begin
				// Gather blue and green, and red as well for 32 bit pixels
				case (phase_q)
					2'd0:    gath_d[7:0]   = din;
					2'd1:    gath_d[15:8]  = din;
					default: gath_d[23:16] = din;
				endcase
				phase_d = phase_q + 2'd1;
			end else begin
				dcolor = {is32 ? din : 8'd0, is24 ? din : gath_q[23:16], gath_q[15:0]};
				n_pix   = col_ok ? 4'd1 : 4'd0;
				gath_d  = 24'd0;
				phase_d = 2'd0;
			end
		end
		new_col  = col_q + COL_W'(n_pix);
		img_done = last_row && (new_col == eff_w) && (n_pix != 4'd0);

		job_d.is_write  = (s_tuser[0] == KIND_PALETTE);
		job_d.pal_idx   = s_tdata[7:0];
		job_d.color     = (s_tuser[0] == KIND_PALETTE) ? s_tdata[39:8] : dcolor;
		job_d.data_byte = din;
		job_d.bpp_log   = bpp_log;
		job_d.direct    = direct;
		job_d.count     = (s_tuser[0] == KIND_PALETTE) ? 4'd0 : n_pix;
		job_d.img_done  = img_done;
	end

	// Hold configuration and stream position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_8BPP;
			width_q       <= DIM_WIDTH'(1);
			height_q      <= DIM_WIDTH'(1);
			top_down_q    <= 1'b0;
			byte_in_row_q <= '0;
			col_q         <= '0;
			rows_done_q   <= '0;
			gath_q        <= '0;
			phase_q       <= '0;
			job_vld_s1    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				// Any register write restarts the image
				case (cfg_index)
					REG_DEPTH_MODE: mode_q     <= cfg_data[2:0];
					REG_WIDTH:      width_q    <= cfg_data;
					REG_HEIGHT:     height_q   <= cfg_data;
					REG_TOP_DOWN:   top_down_q <= cfg_data[0];
					default:        mode_q     <= mode_q;
				endcase
				byte_in_row_q <= '0;
				col_q         <= '0;
				rows_done_q   <= '0;
				gath_q        <= '0;
				phase_q       <= '0;
			end else if (s_acc && s_tuser[0] == KIND_DATA) begin
				if (row_end) begin
					byte_in_row_q <= '0;
					col_q         <= '0;
					gath_q        <= '0;
					phase_q       <= '0;
					if (last_row)
						rows_done_q <= '0;
					else
						rows_done_q <= rows_done_q + HGT_W'(1);
				end else begin
					byte_in_row_q <= byte_inc;
					col_q         <= new_col;
					gath_q        <= gath_d;
					phase_q       <= phase_d;
				end
			end

			if (s_acc)
				job_vld_s1 <= 1'b1;
			else if (job_take)
				job_vld_s1 <= 1'b0;
		end
	end

	// Load the job payload
	always_ff @(posedge clk) begin
		if (s_acc) begin
			job_s1     <= job_d;
			job_col_s1 <= col_q;
			job_row_s1 <= cur_row;
		end
	end

	assign job     = job_s1;
	assign job_vld = job_vld_s1;
	assign job_col = job_col_s1;
	assign job_row = job_row_s1;

endmodule

// File: src/bpr_expand.sv
// ----------------------------------------------------------------------------
// bpr_expand
// Walks a job one pixel per cycle unless the output stalls; owns the palette
// memory and the output register; palette reads land in it with the pixel.
// ----------------------------------------------------------------------------
module bpr_expand import bpr_pkg::*; #(
	parameter int PALETTE_DEPTH = 256,
	parameter int COL_W         = 13,
	parameter int ROW_W         = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  job_t                job,
	input  logic                job_vld,
	input  logic [COL_W-1:0]    job_col,
	input  logic [ROW_W-1:0]    job_row,
	output logic                job_take,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,
	output logic                m_tlast,
	output logic [0:0]          m_tuser
);

	localparam int PAW = $clog2(PALETTE_DEPTH);

	logic [31:0] pal_mem [PALETTE_DEPTH];

	logic [2:0]       k_q;
	logic             out_vld_s2;
	logic [ROW_W-1:0] row_s2;
	logic [COL_W-1:0] col_s2;
	logic             direct_s2, pal_ok_s2, last_s2, done_s2;
	logic [31:0]      color_s2, pal_rd_s2;

	logic        adv, emit, last_k, pal_ok, pal_wr;
	logic [3:0]  sh_amt;
	logic [7:0]  shifted, idx;
	logic [31:0] pix;

	// Pick the pixel index and decide what moves this cycle
	always_comb begin
		adv      = !out_vld_s2 || m_tready;
		emit     = job_vld && !job.is_write && (job.count != 4'd0) && adv;
		last_k   = {1'b0, k_q} == (job.count - 4'd1);
		job_take = job_vld && (job.is_write || job.count == 4'd0 || (adv && last_k));
		sh_amt   = 4'({1'b0, k_q} << job.bpp_log);
		shifted  = job.data_byte << sh_amt;
		case (job.bpp_log)
			2'd0:    idx = {7'd0, shifted[7]};
			2'd1:    idx = {6'd0, shifted[7:6]};
			2'd2:    idx = {4'd0, shifted[7:4]};
			default: idx = shifted;
		endcase
		pal_ok = {1'b0, idx} < 9'(PALETTE_DEPTH);
		pal_wr = job_vld && job.is_write && ({1'b0, job.pal_idx} < 9'(PALETTE_DEPTH));
	end

	// Palette memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (pal_wr)
			pal_mem[job.pal_idx[PAW-1:0]] <= job.color;
		if (emit)
			pal_rd_s2 <= pal_mem[idx[PAW-1:0]];
	end

	// Advance the pixel counter and the output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q        <= '0;
			out_vld_s2 <= 1'b0;
		end else begin
			if (emit)
				k_q <= last_k ? 3'd0 : k_q + 3'd1;
			if (adv)
				out_vld_s2 <= emit;
		end
	end

	// Load the pixel payload
	always_ff @(posedge clk) begin
		if (emit) begin
			row_s2    <= job_row;
			col_s2    <= job_col + COL_W'(k_q);
			direct_s2 <= job.direct;
			color_s2  <= job.color;
			pal_ok_s2 <= pal_ok;
			last_s2   <= last_k;
			done_s2   <= job.img_done && last_k;
		end
	end

	// Select direct or palette colour
	always_comb begin
		if (direct_s2)
			pix = color_s2;
		else if (pal_ok_s2)
			pix = pal_rd_s2;
		else
			pix = 32'd0;
	end

	assign m_tvalid = out_vld_s2;
	assign m_tdata  = {pix[31:24], pix[7:0], pix[15:8], pix[23:16],
	                   COL_OUT_W'(col_s2), ROW_OUT_W'(row_s2)};
	assign m_tlast  = last_s2;
	assign m_tuser  = done_s2;

endmodule

// File: src/bpr_checker.sv
// ----------------------------------------------------------------------------
// bpr_checker
// Port-level checks of the BMP pixel row decoder, bound to the top level.
// ----------------------------------------------------------------------------
module bpr_checker import bpr_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic                m_tlast,
	input logic [0:0]          m_tuser
);

	// Output stays empty while reset is applied
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("output valid during reset");

	// Stalled output holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output changed");

	// Image end only on the last pixel of a byte
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast)
		else $error("image end without run end");

	// Pixels of one byte follow back to back on the same row, next column
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid
			&& m_tdata[11:0] == $past(m_tdata[11:0])
			&& m_tdata[23:12] == 12'($past(m_tdata[23:12]) + 12'd1))
		else $error("run broken");

endmodule

bind bmp_pixel_row_decoder_top bpr_checker u_bpr_checker (.*);

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the BMP pixel row decoder: loads the palette,
// runs directed depth, size and image-wrap cases, then random images with
// random gaps on the input stream and random stalls on the pixel stream.
// Expected pixels come from a cycle-free model of the decoder kept here.
// ----------------------------------------------------------------------------
module testbench;
	import bpr_pkg::*;

	localparam int IMG_LIMIT    = 4096;
	localparam int RANDOM_ITEMS = 80;

	// One expected output pixel
	typedef struct {
		logic [11:0] row;
		logic [11:0] col;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic        last;
		logic        done;
	} pixel_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b1;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata = '0;
	logic [0:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b1;
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  m_tlast;
	logic [0:0]            m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Decoder model state
	logic [31:0]     pal_mem [256];
	logic [2:0]      cfg_mode = MODE_8BPP;
	logic [12:0]     cfg_width = 13'd1;
	logic [12:0]     cfg_height = 13'd1;
	logic            cfg_td = 1'b0;
	int unsigned     pos_in_row = 0;
	int unsigned     col_pos = 0;
	int unsigned     rows_seen = 0;
	int unsigned     row_pos = 0;
	int unsigned     gather_word = 0;
	int unsigned     gather_phase = 0;

	pixel_t          pending_pixels [$];
	int              fail_count = 0;
	int unsigned     burst_left = 0;
	bit              no_gaps = 1'b0;

	bmp_pixel_row_decoder_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Size and depth as the decoder sees them
	function automatic int unsigned eff_width();
		if (cfg_width == 0) return 1;
		if (cfg_width > IMG_LIMIT) return IMG_LIMIT;
		return cfg_width;
	endfunction

	function automatic int unsigned eff_height();
		if (cfg_height == 0) return 1;
		if (cfg_height > IMG_LIMIT) return IMG_LIMIT;
		return cfg_height;
	endfunction

	function automatic int unsigned pixel_bits();
		case (cfg_mode)
			MODE_1BPP:  return 1;
			MODE_2BPP:  return 2;
			MODE_4BPP:  return 4;
			MODE_24BPP: return 24;
			MODE_32BPP: return 32;
			default:    return 8;
		endcase
	endfunction

	// Row length in bytes, padding included
	function automatic int unsigned padded_row();
		return (((eff_width() * pixel_bits() + 7) / 8) + 3) & ~32'd3;
	endfunction

	task automatic restart_position();
		pos_in_row   = 0;
		col_pos      = 0;
		rows_seen    = 0;
		row_pos      = cfg_td ? 0 : eff_height() - 1;
		gather_word  = 0;
		gather_phase = 0;
	endtask

	// Queue one pixel at the current position and advance the column
	task automatic push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
		pixel_t p;
		p.row   = row_pos[11:0];
		p.col   = col_pos[11:0];
		p.red   = r;
		p.green = g;
		p.blue  = b;
		p.alpha = a;
		p.last  = 1'b0;
		p.done  = (col_pos == eff_width() - 1) && (rows_seen == eff_height() - 1);
		pending_pixels.push_back(p);
		col_pos++;
	endtask

	// Work out the pixels that one accepted item gives
	task automatic predict_pixels(logic kind, logic [7:0] idx, logic [31:0] color,
			logic [7:0] data_val);
		int unsigned w, bits, nbytes, cnt, mask, pix_idx, k, final_phase;
		logic [31:0] e;
		int n;
		w = eff_width();
		bits = pixel_bits();
		nbytes = (w * bits + 7) / 8;
		n = 0;
		if (kind == KIND_PALETTE) begin
			pal_mem[idx] = color;
			return;
		end
		if (pos_in_row < nbytes) begin
			if (bits <= 8) begin
				cnt = 8 / bits;
				mask = (1 << bits) - 1;
				for (k = 0; k < cnt && col_pos < w; k++) begin
					pix_idx = (data_val >> (8 - bits * (k + 1))) & mask;
					e = pal_mem[pix_idx];
					push_pixel(e[23:16], e[15:8], e[7:0], e[31:24]);
					n++;
				end
			end else begin
				final_phase = (bits == 24) ? 2 : 3;
				if (gather_phase < final_phase) begin
					gather_word |= data_val << (8 * gather_phase);
					gather_phase++;
				end else begin
					if (bits == 24) gather_word |= data_val << 16;
					if (col_pos < w) begin
						push_pixel(gather_word[23:16], gather_word[15:8], gather_word[7:0],
							(bits == 32) ? data_val : 8'd0);
						n++;
					end
					gather_word = 0;
					gather_phase = 0;
				end
			end
		end
		if (n > 0) pending_pixels[pending_pixels.size() - 1].last = 1'b1;

		// Advance through the row and wrap rows at the image end
		pos_in_row++;
		if (pos_in_row >= padded_row()) begin
			pos_in_row = 0;
			col_pos = 0;
			gather_word = 0;
			gather_phase = 0;
			rows_seen++;
			if (rows_seen >= eff_height()) begin
				rows_seen = 0;
				row_pos = cfg_td ? 0 : eff_height() - 1;
			end else if (cfg_td) begin
				row_pos++;
			end else begin
				row_pos--;
			end
		end
	endtask

	// Drive one input item and hold it until the transfer completes
	task automatic send_item(logic kind, logic [7:0] idx, logic [31:0] color,
			logic [7:0] data_val);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {data_val, color, idx};
		do @(posedge clk); while (!s_tready);
		predict_pixels(kind, idx, color, data_val);
	endtask

	task automatic send_data(logic [7:0] data_val);
		send_item(KIND_DATA, 8'($urandom), $urandom, data_val);
	endtask

	task automatic send_entry(logic [7:0] idx, logic [31:0] color);
		send_item(KIND_PALETTE, idx, color, 8'($urandom));
	endtask

	// Drop valid for a number of cycles
	task automatic hold_off(int unsigned cycles);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// Open a new burst with a random gap when the current one runs out
	task automatic pace();
		if (burst_left == 0) begin
			if (!no_gaps) hold_off($urandom_range(1, 6));
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
	endtask

	// Wait until every expected pixel has arrived and the pipeline is empty
	task automatic wait_drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_DEPTH_MODE: cfg_mode   = val[2:0];
			REG_WIDTH:      cfg_width  = val;
			REG_HEIGHT:     cfg_height = val;
			REG_TOP_DOWN:   cfg_td     = val[0];
			default: ;
		endcase
		restart_position();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_format(logic [2:0] mode, logic [12:0] w, logic [12:0] h, logic td);
		write_reg(REG_DEPTH_MODE, 13'(mode));
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_TOP_DOWN, 13'(td));
	endtask

	// Fill every palette entry; entry 0 all zeros, entry 255 all ones
	task automatic test_palette_load();
		int i;
		for (i = 0; i < 256; i++) begin
			pace();
			send_entry(8'(i), (i == 0) ? 32'h0 : (i == 255) ? 32'hFFFF_FFFF : $urandom);
		end
	endtask

	// Each depth mode, the two unused codes included, on a short row
	task automatic test_depth_modes();
		logic [7:0] probe [8];
		int m;
		probe = '{8'hB4, 8'h1B, 8'hF0, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h5A};
		for (m = 0; m < 8; m++) begin
			wait_drain();
			set_format(3'(m), 13'd3, 13'd2, m[0]);
			if (m == MODE_24BPP) begin
				send_data(8'hFF);
				send_data(8'h00);
				send_data(8'h80);
			end else if (m == MODE_32BPP) begin
				send_data(8'h01);
				send_data(8'h02);
				send_data(8'h03);
				send_data(8'hFF);
			end else begin
				send_data(probe[m]);
			end
		end
	endtask

	// Zero and oversized width and height, largest image bottom-up
	task automatic test_size_limits();
		wait_drain();
		set_format(MODE_32BPP, 13'h1FFF, 13'd0, 1'b0);
		send_data(8'h11);
		send_data(8'h22);
		send_data(8'h33);
		send_data(8'h44);
		wait_drain();
		set_format(MODE_1BPP, 13'd4096, 13'd4096, 1'b0);
		send_data(8'hC3);
		wait_drain();
		set_format(MODE_8BPP, 13'd0, 13'h1FFF, 1'b1);
		send_data(8'h80);
	endtask

	// Full 2-bit image with dropped pixels and padding, then wrap to row one
	task automatic test_image_wrap();
		int k;
		wait_drain();
		set_format(MODE_2BPP, 13'd5, 13'd2, 1'b0);
		for (k = 0; k < 9; k++) send_data(8'($urandom));
	endtask

	// Random formats, mostly whole images, some cut short, palette writes mixed in
	task automatic test_random_images();
		int unsigned sent, total, k;
		logic [2:0]  mode;
		logic [12:0] w, h;
		bit          partial;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			mode = 3'($urandom_range(0, 7));
			partial = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 9) == 0) begin
				w = 13'($urandom_range(13, 8191));
				h = 13'($urandom_range(0, 8191));
				partial = 1'b1;
			end else begin
				w = 13'($urandom_range(1, 8));
				h = 13'($urandom_range(1, 3));
			end
			no_gaps = ($urandom_range(0, 3) == 0);
			wait_drain();
			set_format(mode, w, h, 1'($urandom_range(0, 1)));
			total = padded_row() * eff_height();
			if (partial) total = $urandom_range(1, (total < 24) ? total : 24);
			for (k = 0; k < total; k++) begin
				pace();
				if ($urandom_range(0, 15) == 0) send_entry(8'($urandom), $urandom);
				else send_data(8'($urandom));
				sent++;
			end
		end
	endtask

	// Receiver stalls: m_tready steps through a random ready word, re-picked after each pass
	logic [31:0] ready_word = '1;
	int unsigned ready_bit = 0;
	always @(negedge clk) begin
		if (ready_bit == 0) begin
			case ($urandom_range(0, 3))
				0: ready_word <= '1;
				1: ready_word <= $urandom;
				2: ready_word <= $urandom | $urandom;
				default: ready_word <= $urandom & $urandom;
			endcase
		end
		m_tready <= ready_word[ready_bit];
		ready_bit <= (ready_bit + 1) % 32;
	end

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			if (fail_count < 40) $error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Compare each pixel transfer with the oldest expectation
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pixels.size() == 0) begin
				if (fail_count < 40) $error("pixel: expected none, got row %0d col %0d",
					m_tdata[11:0], m_tdata[23:12]);
				fail_count++;
			end else begin
				want = pending_pixels.pop_front();
				check_field("pixel_row", want.row, m_tdata[11:0]);
				check_field("pixel_col", want.col, m_tdata[23:12]);
				check_field("red", want.red, m_tdata[31:24]);
				check_field("green", want.green, m_tdata[39:32]);
				check_field("blue", want.blue, m_tdata[47:40]);
				check_field("alpha", want.alpha, m_tdata[55:48]);
				check_field("last_in_run", want.last, m_tlast);
				check_field("image_done", want.done, m_tuser[0]);
			end
		end
	end

	// Stop a hung run
	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		restart_position();
		// Assert reset with a real falling edge ahead of the first clock edge
		#1;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_palette_load();
		test_depth_modes();
		test_size_limits();
		test_image_wrap();
		test_random_images();

		wait_drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending_pixels.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
